[sv/tnn_pkg.sv]
// ----------------------------------------------------------------------------
// tnn_pkg
// shared constants, types and helpers for the type name normalizer
// ----------------------------------------------------------------------------
package tnn_pkg;

  localparam int CHAR_W           = 16;
  localparam int SUFFIX_DEPTH_DEF = 8;

  localparam logic [CHAR_W-1:0] CH_LOWER_U = CHAR_W'("u");
  localparam logic [CHAR_W-1:0] CH_UPPER_U = CHAR_W'("U");
  localparam logic [CHAR_W-1:0] CH_LOWER_L = CHAR_W'("l");
  localparam logic [CHAR_W-1:0] CH_UPPER_L = CHAR_W'("L");
  localparam logic [CHAR_W-1:0] CH_GT      = CHAR_W'(">");
  localparam logic [CHAR_W-1:0] CH_COMMA   = CHAR_W'(",");
  localparam logic [CHAR_W-1:0] CH_STAR    = CHAR_W'("*");
  localparam logic [CHAR_W-1:0] CH_AMP     = CHAR_W'("&");
  localparam logic [CHAR_W-1:0] CH_LT      = CHAR_W'("<");
  localparam logic [CHAR_W-1:0] CH_LPAREN  = CHAR_W'("(");
  localparam logic [CHAR_W-1:0] CH_UNDER   = CHAR_W'("_");
  localparam logic [CHAR_W-1:0] CH_SPACE   = CHAR_W'(" ");

  typedef enum logic [1:0] {
    SFX_LOWER_U = 2'd0,
    SFX_UPPER_U = 2'd1,
    SFX_LOWER_L = 2'd2,
    SFX_UPPER_L = 2'd3
  } sfx_code_t;

  // one classified input word, as handed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              flush;
    logic              space;
    logic              emit_char;
    logic              last;
    logic              ovf;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] suffix_char(input logic [1:0] code);
    logic [CHAR_W-1:0] c;
    unique case (sfx_code_t'(code))
      SFX_LOWER_U: c = CH_LOWER_U;
      SFX_UPPER_U: c = CH_UPPER_U;
      SFX_LOWER_L: c = CH_LOWER_L;
      SFX_UPPER_L: c = CH_UPPER_L;
      default:     c = CH_LOWER_U;
    endcase
    return c;
  endfunction

endpackage

[sv/tnn_if.sv]
// ----------------------------------------------------------------------------
// tnn_if
// valid/ready channels for name characters in and normalized words out
// ----------------------------------------------------------------------------
interface tnn_in_if;
  import tnn_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_name;

  modport source(output valid, ch, end_of_name, input ready);
  modport sink(input valid, ch, end_of_name, output ready);
endinterface

interface tnn_out_if;
  import tnn_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              last_of_name;
  logic              suffix_overflow;

  modport source(output valid, out_char, char_valid, last_of_name, suffix_overflow,
                 input ready);
  modport sink(input valid, out_char, char_valid, last_of_name, suffix_overflow,
               output ready);
endinterface

[sv/tnn_front.sv]
// ----------------------------------------------------------------------------
// tnn_front
// scans input characters, tracks literal / suffix / whitespace state and
// issues one command per word that produces output
// ----------------------------------------------------------------------------
module tnn_front #(
  parameter int SUFFIX_DEPTH = tnn_pkg::SUFFIX_DEPTH_DEF,
  parameter int ENTRY_W      = $bits(tnn_pkg::cmd_t) + $clog2(SUFFIX_DEPTH + 1)
                               + 2 * SUFFIX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  tnn_in_if.sink             din,
  input  logic               q_ready,
  output logic               push,
  output logic [ENTRY_W-1:0] push_data
);
  import tnn_pkg::*;

  localparam int CNT_W = $clog2(SUFFIX_DEPTH + 1);
  localparam int IDX_W = $clog2(SUFFIX_DEPTH);

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_DIGITS = 4'b0010,
    MODE_SUFFIX = 4'b0100,
    MODE_SPACE  = 4'b1000
  } mode_t;

  mode_t             mode, mode_next;
  logic              prev_ident, prev_ident_next;
  logic [CHAR_W-1:0] last_emitted, last_emitted_next;
  logic              nothing_emitted, nothing_emitted_next;
  logic [CNT_W-1:0]  sfx_cnt, sfx_cnt_next;
  logic              ovf, ovf_next;
  logic [1:0]        sfx_store [SUFFIX_DEPTH];

  logic              accept;
  logic [CHAR_W-1:0] c;
  logic              is_dig, is_alpha, is_ident, is_spc, is_code;
  logic [1:0]        code;
  logic              go_plain, pi_in, drop;
  logic              sfx_we;
  logic [IDX_W-1:0]  sfx_wa;
  logic              ovf_step;
  cmd_t              cmd;
  logic [2*SUFFIX_DEPTH-1:0] sfx_flat;

  assign accept = din.valid && din.ready;
  assign c      = din.ch;

  always_comb begin
    is_dig   = (c >= CHAR_W'("0")) && (c <= CHAR_W'("9"));
    is_alpha = ((c >= CHAR_W'("a")) && (c <= CHAR_W'("z")))
            || ((c >= CHAR_W'("A")) && (c <= CHAR_W'("Z")));
    is_ident = is_dig || is_alpha || (c == CH_UNDER);
    is_spc   = (c == CH_SPACE) || ((c >= CHAR_W'(9)) && (c <= CHAR_W'(13)));
    is_code  = 1'b1;
    code     = SFX_LOWER_U;
    case (c)
      CH_LOWER_U: code = SFX_LOWER_U;
      CH_UPPER_U: code = SFX_UPPER_U;
      CH_LOWER_L: code = SFX_LOWER_L;
      CH_UPPER_L: code = SFX_UPPER_L;
      default:    is_code = 1'b0;
    endcase
  end

  always_comb begin
    mode_next            = mode;
    prev_ident_next      = prev_ident;
    last_emitted_next    = last_emitted;
    nothing_emitted_next = nothing_emitted;
    sfx_cnt_next         = sfx_cnt;
    ovf_next             = ovf;
    cmd                  = '0;
    cmd.ch               = c;
    go_plain             = 1'b0;
    pi_in                = prev_ident;
    drop                 = 1'b0;
    sfx_we               = 1'b0;
    sfx_wa               = '0;

    unique case (mode)
      MODE_DIGITS: begin
        if (is_dig) begin
          cmd.emit_char = 1'b1;
        end else if (is_code) begin
          sfx_cnt_next = CNT_W'(1);
          sfx_we       = 1'b1;
          mode_next    = MODE_SUFFIX;
        end else begin
          mode_next = MODE_NORMAL;
          pi_in     = 1'b0;
          go_plain  = 1'b1;
        end
      end
      MODE_SUFFIX: begin
        if (is_code) begin
          if (sfx_cnt < CNT_W'(SUFFIX_DEPTH)) begin
            sfx_we       = 1'b1;
            sfx_wa       = sfx_cnt[IDX_W-1:0];
            sfx_cnt_next = sfx_cnt + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
        end else begin
          cmd.flush    = is_ident;
          pi_in        = is_ident;
          sfx_cnt_next = '0;
          mode_next    = MODE_NORMAL;
          go_plain     = 1'b1;
        end
      end
      MODE_SPACE: begin
        if (!is_spc) begin
          drop = (c == CH_GT) || (c == CH_COMMA) || (c == CH_STAR) || (c == CH_AMP)
              || (!nothing_emitted
                  && ((last_emitted == CH_LT) || (last_emitted == CH_LPAREN)));
          cmd.space = !drop;
          mode_next = MODE_NORMAL;
          pi_in     = 1'b0;
          go_plain  = 1'b1;
        end
      end
      MODE_NORMAL: go_plain = 1'b1;
      default:     go_plain = 1'b1;
    endcase

    if (go_plain) begin
      if (is_spc) begin
        mode_next       = MODE_SPACE;
        prev_ident_next = 1'b0;
      end else if (is_dig && !pi_in) begin
        mode_next       = MODE_DIGITS;
        prev_ident_next = pi_in;
        cmd.emit_char   = 1'b1;
      end else begin
        prev_ident_next = is_ident;
        cmd.emit_char   = 1'b1;
      end
    end

    if (cmd.emit_char) begin
      last_emitted_next    = c;
      nothing_emitted_next = 1'b0;
    end

    ovf_step = ovf_next;
    cmd.ovf  = ovf_step;
    cmd.last = din.end_of_name;

    // end of name returns everything to the idle scan state
    if (din.end_of_name) begin
      mode_next            = MODE_NORMAL;
      prev_ident_next      = 1'b0;
      last_emitted_next    = '0;
      nothing_emitted_next = 1'b1;
      sfx_cnt_next         = '0;
      ovf_next             = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < SUFFIX_DEPTH; i++) begin
      sfx_flat[2*i +: 2] = sfx_store[i];
    end
  end

  assign din.ready = q_ready;
  assign push      = accept && (cmd.emit_char || cmd.last);
  assign push_data = {cmd, sfx_cnt, sfx_flat};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      prev_ident      <= 1'b0;
      last_emitted    <= '0;
      nothing_emitted <= 1'b1;
      sfx_cnt         <= '0;
      ovf             <= 1'b0;
    end else if (accept) begin
      mode            <= mode_next;
      prev_ident      <= prev_ident_next;
      last_emitted    <= last_emitted_next;
      nothing_emitted <= nothing_emitted_next;
      sfx_cnt         <= sfx_cnt_next;
      ovf             <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sfx_we) begin
      sfx_store[sfx_wa] <= code;
    end
  end

  a_eon_clears: assert property (@(posedge clk) disable iff (rst)
    accept && din.end_of_name |=>
      mode == MODE_NORMAL && nothing_emitted && !ovf && sfx_cnt == '0)
    else $error("scan state not cleared after end of name");

endmodule

[sv/tnn_queue.sv]
// ----------------------------------------------------------------------------
// tnn_queue
// two-entry command queue between the scanner and the output sequencer
// ----------------------------------------------------------------------------
module tnn_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  output logic             valid,
  output logic [WIDTH-1:0] rdata,
  input  logic             pop
);
  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("queue popped while empty");

endmodule

[sv/tnn_back.sv]
// ----------------------------------------------------------------------------
// tnn_back
// expands each command into output words: held suffix, space, character
// or bare end marker, through a registered output stage
// ----------------------------------------------------------------------------
module tnn_back #(
  parameter int SUFFIX_DEPTH = tnn_pkg::SUFFIX_DEPTH_DEF,
  parameter int ENTRY_W      = $bits(tnn_pkg::cmd_t) + $clog2(SUFFIX_DEPTH + 1)
                               + 2 * SUFFIX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               pop,
  tnn_out_if.source          dout
);
  import tnn_pkg::*;

  localparam int CNT_W = $clog2(SUFFIX_DEPTH + 1);
  localparam int IDX_W = $clog2(SUFFIX_DEPTH);

  cmd_t                      hd;
  logic [CNT_W-1:0]          hd_cnt;
  logic [2*SUFFIX_DEPTH-1:0] hd_flat;
  logic [1:0]                hd_sfx [SUFFIX_DEPTH];

  logic [CNT_W-1:0]  sidx;
  logic              sp_done;
  logic              in_sfx, in_sp, final_word, load;
  logic [CHAR_W-1:0] item_char;
  logic              item_cv, item_last;

  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_cv, out_last, out_ovf;

  assign {hd, hd_cnt, hd_flat} = q_data;

  always_comb begin
    for (int i = 0; i < SUFFIX_DEPTH; i++) begin
      hd_sfx[i] = hd_flat[2*i +: 2];
    end
  end

  always_comb begin
    in_sfx     = hd.flush && (sidx < hd_cnt);
    in_sp      = !in_sfx && hd.space && !sp_done;
    final_word = !in_sfx && !in_sp;
    if (in_sfx) begin
      item_char = suffix_char(hd_sfx[sidx[IDX_W-1:0]]);
    end else if (in_sp) begin
      item_char = CH_SPACE;
    end else if (hd.emit_char) begin
      item_char = hd.ch;
    end else begin
      item_char = '0;
    end
    item_cv   = in_sfx || in_sp || hd.emit_char;
    item_last = final_word && hd.last;
  end

  assign load = q_valid && (!out_valid || dout.ready);
  assign pop  = load && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      sidx      <= '0;
      sp_done   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        if (final_word) begin
          sidx    <= '0;
          sp_done <= 1'b0;
        end else if (in_sfx) begin
          sidx <= sidx + CNT_W'(1);
        end else begin
          sp_done <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= item_char;
      out_cv   <= item_cv;
      out_last <= item_last;
      out_ovf  <= hd.ovf;
    end
  end

  assign dout.valid           = out_valid;
  assign dout.out_char        = out_char;
  assign dout.char_valid      = out_cv;
  assign dout.last_of_name    = out_last;
  assign dout.suffix_overflow = out_ovf;

  a_sidx_bound: assert property (@(posedge clk) disable iff (rst)
    q_valid && hd.flush |-> sidx <= hd_cnt)
    else $error("suffix index past held count");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_cv |-> out_last)
    else $error("bare end marker without last flag");

endmodule

[sv/type_name_normalizer.sv]
// ----------------------------------------------------------------------------
// type_name_normalizer
// normalizes a type name streamed one code unit per word: literal suffixes,
// whitespace runs and end-of-name handling
//
//   channel  dir  fields                                           handshake
//   din      in   ch[15:0], end_of_name                            valid/ready
//   dout     out  out_char[15:0], char_valid, last_of_name,        valid/ready
//                 suffix_overflow
//
// one input word per cycle while the command queue has room; a word that releases a held
// suffix of k characters expands into k+1 output words, a word behind a kept space
// into two, every other word that produces output into one
// input stalls only when the two-entry command queue is full
// synchronous reset clears scan state, queue and output stage; no clearing pass
// ----------------------------------------------------------------------------
module type_name_normalizer #(
  parameter int SUFFIX_DEPTH = tnn_pkg::SUFFIX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tnn_in_if.sink     din,
  tnn_out_if.source  dout
);
  import tnn_pkg::*;

  localparam int ENTRY_W = $bits(cmd_t) + $clog2(SUFFIX_DEPTH + 1) + 2 * SUFFIX_DEPTH;

  logic               push, q_ready, q_valid, pop;
  logic [ENTRY_W-1:0] push_data, q_data;

  tnn_front #(
    .SUFFIX_DEPTH(SUFFIX_DEPTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .q_ready  (q_ready),
    .push     (push),
    .push_data(push_data)
  );

  tnn_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_data),
    .ready(q_ready),
    .valid(q_valid),
    .rdata(q_data),
    .pop  (pop)
  );

  tnn_back #(
    .SUFFIX_DEPTH(SUFFIX_DEPTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_data),
    .pop    (pop),
    .dout   (dout)
  );

endmodule
